/* sv/bhs_pkg.sv */
// bhs_pkg: shared constants, register codes and structs of the height sampler
// used by bhs_front, bhs_fifo, bhs_back and bspline_height_sampler_core
package bhs_pkg;

    localparam int GRID_SIDE_DEF   = 256;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CELL_CNT_W      = 21;

    // datapath widths
    localparam int SAMP_W = 42;
    localparam int ROW_W  = 44;
    localparam int ACC_W  = 64;
    localparam int WGT_W  = 16;
    localparam int NUM_W  = 52;

    // reciprocal of six for the weight rounding
    localparam logic [21:0] RECIP6       = 22'd2796203;
    localparam int          RECIP6_SHIFT = 24;

    // register reset values
    localparam logic [31:0] MIN_RESET    = 32'd0;
    localparam logic [31:0] MAX_RESET    = 32'd1048576;
    localparam logic [31:0] SCALE_RESET  = 32'd65536;
    localparam logic [31:0] OFFSET_RESET = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X,
        REG_MAX_X,
        REG_MIN_Y,
        REG_MAX_Y,
        REG_CODE_SCALE,
        REG_CODE_OFFSET
    } bhs_reg_t;

    // one classified transaction between front and back
    typedef struct packed {
        logic        is_query;
        logic [15:0] addr;
        logic [15:0] code;
        logic [31:0] dx;
        logic [31:0] dy;
    } bhs_item_t;

    // configuration as seen by the back end
    typedef struct packed {
        logic [31:0]        span_x;
        logic [31:0]        span_y;
        logic [31:0]        scale;
        logic signed [31:0] offset;
    } bhs_cfg_t;

endpackage

/* sv/bhs_front.sv */
// bhs_front: configuration registers, input acceptance and classification
// depends on bhs_pkg
module bhs_front #(
    parameter int GRID_SIDE = bhs_pkg::GRID_SIDE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic                           kind,
    input  logic [15:0]                    cell_index,
    input  logic [15:0]                    cell_code,
    input  logic signed [31:0]             query_x_cm,
    input  logic signed [31:0]             query_y_cm,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bhs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           q_full,
    output logic                           q_push,
    output bhs_pkg::bhs_item_t             q_item,
    output bhs_pkg::bhs_cfg_t              cfg
);
    import bhs_pkg::*;

    localparam logic [CELL_CNT_W-1:0] CELLS = CELL_CNT_W'(GRID_SIDE * GRID_SIDE);

    logic [31:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [31:0] scale_reg, offset_reg;
    logic        in_range;

    // signed extent of one axis
    function automatic logic signed [32:0] axis_span(input logic [31:0] lo,
                                                     input logic [31:0] hi);
        return $signed({hi[31], hi}) - $signed({lo[31], lo});
    endfunction

    // clamped offset of a position into the extent, zero when degenerate
    function automatic logic [31:0] axis_offset(input logic [31:0] p,
                                                input logic [31:0] lo,
                                                input logic [31:0] hi);
        logic signed [32:0] span;
        logic signed [32:0] d;
        span = axis_span(lo, hi);
        d    = $signed({p[31], p}) - $signed({lo[31], lo});
        if (span <= 33'sd0)
            return 32'd0;
        if (d < 33'sd0)
            return 32'd0;
        if (d > span)
            return span[31:0];
        return d[31:0];
    endfunction

    // divisor for the back end, forced to one on a degenerate axis
    function automatic logic [31:0] axis_divisor(input logic [31:0] lo,
                                                 input logic [31:0] hi);
        logic signed [32:0] span;
        span = axis_span(lo, hi);
        return (span > 33'sd0) ? span[31:0] : 32'd1;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg  <= MIN_RESET;
            max_x_reg  <= MAX_RESET;
            min_y_reg  <= MIN_RESET;
            max_y_reg  <= MAX_RESET;
            scale_reg  <= SCALE_RESET;
            offset_reg <= OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (bhs_reg_t'(cfg_index))
                REG_MIN_X:       min_x_reg  <= cfg_data;
                REG_MAX_X:       max_x_reg  <= cfg_data;
                REG_MIN_Y:       min_y_reg  <= cfg_data;
                REG_MAX_Y:       max_y_reg  <= cfg_data;
                REG_CODE_SCALE:  scale_reg  <= cfg_data;
                REG_CODE_OFFSET: offset_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // configuration view for the back end
    assign cfg.span_x = axis_divisor(min_x_reg, max_x_reg);
    assign cfg.span_y = axis_divisor(min_y_reg, max_y_reg);
    assign cfg.scale  = scale_reg;
    assign cfg.offset = $signed(offset_reg);

    // classify: stores outside the grid are accepted and dropped
    assign in_range        = CELL_CNT_W'(cell_index) < CELLS;
    assign full            = q_full;
    assign q_push          = push && !q_full && (kind || in_range);
    assign q_item.is_query = kind;
    assign q_item.addr     = cell_index;
    assign q_item.code     = cell_code;
    assign q_item.dx       = axis_offset(query_x_cm, min_x_reg, max_x_reg);
    assign q_item.dy       = axis_offset(query_y_cm, min_y_reg, max_y_reg);

endmodule

/* sv/bhs_fifo.sv */
// bhs_fifo: short queue of classified transactions between front and back
// depends on bhs_pkg
module bhs_fifo #(
    parameter int DEPTH = bhs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bhs_pkg::bhs_item_t push_item,
    output logic               full,
    input  logic               pop,
    output bhs_pkg::bhs_item_t pop_item,
    output logic               empty
);
    import bhs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bhs_item_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

endmodule

/* sv/bhs_back.sv */
// bhs_back: grid memory, coordinate divider, spline weights, filter and result
// depends on bhs_pkg
module bhs_back #(
    parameter int GRID_SIDE = bhs_pkg::GRID_SIDE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    output logic               q_pop,
    input  bhs_pkg::bhs_item_t q_item,
    input  bhs_pkg::bhs_cfg_t  cfg,
    input  logic               res_pop,
    output logic               res_empty,
    output logic [31:0]        res_height
);
    import bhs_pkg::*;

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int QW    = CW + 16;
    localparam int PW    = 32 + CW;
    localparam int CAW   = $clog2(GRID_SIDE * GRID_SIDE);
    localparam int DCW   = $clog2(QW);
    localparam int MPW   = ROW_W + WGT_W + 1;
    localparam logic [NUM_W-1:0] U3   = NUM_W'(1) << 48;
    localparam logic [NUM_W-1:0] HALF = NUM_W'(3) << 32;
    localparam logic signed [ROW_W-1:0] SAT_HI = ROW_W'(32'sh7FFFFFFF);
    localparam logic signed [ROW_W-1:0] SAT_LO = ROW_W'(32'sh80000000);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_LOAD, ST_DIV, ST_SQR, ST_CUBE, ST_NUM, ST_WGT,
        ST_FETCH, ST_ROWS, ST_COLS, ST_WAIT, ST_DONE
    } state_t;

    typedef struct packed {
        logic       colpass;
        logic [3:0] idx;
    } mac_tag_t;

    state_t state_reg, state_next;

    // control
    logic             axis_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic [3:0]       fcnt_reg;
    logic [1:0]       ccnt_reg;
    logic             res_valid_reg;
    logic [31:0]      res_reg;

    // divider
    logic [31:0]      dx_reg, dy_reg;
    logic [PW-1:0]    prod_reg;
    logic [31:0]      rem_reg;
    logic [QW-1:0]    quo_reg;
    logic [QW-1:0]    sx_reg, sy_reg;
    logic [31:0]      cur_span;
    logic [32:0]      div_r2;
    logic             div_ge;

    // weights
    logic [15:0]      t_cur;
    logic [16:0]      om_cur;
    logic [31:0]      t2_reg;
    logic [32:0]      o2_reg;
    logic [47:0]      t3_reg;
    logic [48:0]      o3_reg;
    logic [NUM_W-1:0] n_val [4];
    logic [19:0]      num_reg [4];
    logic [WGT_W-1:0] wx_reg [4];
    logic [WGT_W-1:0] wy_reg [4];

    // memory and sample pipeline
    logic [15:0]      grid_mem [GRID_SIDE * GRID_SIDE];
    logic             mem_we, mem_re;
    logic [CAW-1:0]   wr_addr, rd_addr;
    logic [CW-1:0]    rd_col, rd_row;
    logic [15:0]      rdata_reg;
    logic             v1_reg, v2_reg, v3_reg, mv_reg;
    logic [3:0]       tag1_reg, tag2_reg, tag3_reg;
    logic [47:0]      dprod_reg;
    logic signed [SAMP_W-1:0] samp_reg, lo_reg, hi_reg;

    // multiply-accumulate
    logic                     col_issue;
    logic signed [ROW_W-1:0]  mul_a;
    logic signed [WGT_W:0]    mul_w;
    logic signed [MPW-1:0]    mprod_reg;
    mac_tag_t                 mtag_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_sum, acc_rnd;
    logic signed [ROW_W-1:0]  row_reg [4];
    logic signed [ROW_W-1:0]  fin_reg;
    logic                     row_done, col_done;

    // result
    logic signed [ROW_W-1:0]  lo_e, hi_e, h_clamp, h_sat;
    logic                     res_load;

    // edge-clamped neighbor index
    function automatic logic [CW-1:0] nb_index(input logic [CW-1:0] base,
                                               input logic [1:0] off);
        logic [CW-1:0] last;
        last = CW'(GRID_SIDE - 1);
        case (off)
            2'd0:    return (base == '0) ? '0 : base - 1'b1;
            2'd1:    return base;
            2'd2:    return (base >= last) ? last : base + 1'b1;
            2'd3:    return (base >= last - 1'b1) ? last : base + CW'(2);
            default: return base;
        endcase
    endfunction

    // restoring divider step
    assign cur_span = axis_reg ? cfg.span_y : cfg.span_x;
    assign div_r2   = {rem_reg, quo_reg[QW-1]};
    assign div_ge   = div_r2 >= {1'b0, cur_span};

    // weight numerators over six times two to the 48
    assign t_cur  = axis_reg ? sy_reg[15:0] : sx_reg[15:0];
    assign om_cur = 17'd65536 - {1'b0, t_cur};
    assign n_val[0] = NUM_W'(o3_reg);
    assign n_val[1] = NUM_W'(3) * NUM_W'(t3_reg) + (U3 << 2)
                    - NUM_W'(6) * (NUM_W'(t2_reg) << 16);
    assign n_val[2] = NUM_W'(3) * (NUM_W'(t2_reg) << 16) + NUM_W'(3) * (NUM_W'(t_cur) << 32)
                    + U3 - NUM_W'(3) * NUM_W'(t3_reg);
    assign n_val[3] = NUM_W'(t3_reg);

    // grid addressing
    assign q_pop   = (state_reg == ST_IDLE) && !q_empty;
    assign mem_we  = q_pop && !q_item.is_query;
    assign mem_re  = state_reg == ST_FETCH;
    assign wr_addr = CAW'(q_item.addr);
    assign rd_col  = nb_index(sx_reg[QW-1:16], fcnt_reg[1:0]);
    assign rd_row  = nb_index(sy_reg[QW-1:16], fcnt_reg[3:2]);
    assign rd_addr = CAW'(rd_row) * CAW'(GRID_SIDE) + CAW'(rd_col);

    // multiplier operand select: row pass or column pass
    assign col_issue = state_reg == ST_COLS;
    assign mul_a = col_issue ? row_reg[ccnt_reg] : ROW_W'(samp_reg);
    assign mul_w = $signed({1'b0, col_issue ? wy_reg[ccnt_reg] : wx_reg[tag3_reg[1:0]]});

    // accumulate and round half up
    assign acc_sum  = ((mtag_reg.idx[1:0] == 2'd0) ? '0 : acc_reg) + ACC_W'(mprod_reg);
    assign acc_rnd  = (acc_sum + ACC_W'(32768)) >>> 16;
    assign row_done = mv_reg && !mtag_reg.colpass && (mtag_reg.idx == 4'd15);
    assign col_done = mv_reg && mtag_reg.colpass && (mtag_reg.idx[1:0] == 2'd3);

    // neighborhood clamp and saturation
    assign lo_e     = ROW_W'(lo_reg);
    assign hi_e     = ROW_W'(hi_reg);
    assign h_clamp  = (fin_reg < lo_e) ? lo_e : ((fin_reg > hi_e) ? hi_e : fin_reg);
    assign h_sat    = (h_clamp > SAT_HI) ? SAT_HI : ((h_clamp < SAT_LO) ? SAT_LO : h_clamp);
    assign res_load = (state_reg == ST_DONE) && !res_valid_reg;

    assign res_empty  = !res_valid_reg;
    assign res_height = res_reg;

    // grid memory, single port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[wr_addr] <= q_item.code;
        if (mem_re)
            rdata_reg <= grid_mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (q_pop && q_item.is_query) state_next = ST_MUL;
            ST_MUL:   state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV:   if (div_cnt_reg == DCW'(QW - 1))
                          state_next = axis_reg ? ST_SQR : ST_MUL;
            ST_SQR:   state_next = ST_CUBE;
            ST_CUBE:  state_next = ST_NUM;
            ST_NUM:   state_next = ST_WGT;
            ST_WGT:   state_next = axis_reg ? ST_FETCH : ST_SQR;
            ST_FETCH: if (fcnt_reg == 4'd15) state_next = ST_ROWS;
            ST_ROWS:  if (row_done) state_next = ST_COLS;
            ST_COLS:  if (ccnt_reg == 2'd3) state_next = ST_WAIT;
            ST_WAIT:  if (col_done) state_next = ST_DONE;
            ST_DONE:  if (res_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state, counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            div_cnt_reg   <= '0;
            fcnt_reg      <= '0;
            ccnt_reg      <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:  axis_reg <= 1'b0;
                ST_LOAD:  div_cnt_reg <= '0;
                ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DCW'(QW - 1))
                        axis_reg <= !axis_reg;
                end
                ST_WGT:
                begin
                    axis_reg <= !axis_reg;
                    fcnt_reg <= '0;
                end
                ST_FETCH: fcnt_reg <= fcnt_reg + 1'b1;
                ST_ROWS:  ccnt_reg <= '0;
                ST_COLS:  ccnt_reg <= ccnt_reg + 1'b1;
                default:  ;
            endcase
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= h_sat[31:0];
            end
            else if (res_pop && res_valid_reg)
                res_valid_reg <= 1'b0;
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            mv_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= mem_re;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            mv_reg <= v3_reg || col_issue;
        end
    end

    // divider and weight datapath
    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.is_query)
        begin
            dx_reg <= q_item.dx;
            dy_reg <= q_item.dy;
        end
        if (state_reg == ST_MUL)
            prod_reg <= PW'(axis_reg ? dy_reg : dx_reg) * PW'(GRID_SIDE - 1);
        if (state_reg == ST_LOAD)
        begin
            rem_reg <= prod_reg[PW-1:CW];
            quo_reg <= {prod_reg[CW-1:0], 16'b0};
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= div_ge ? 32'(div_r2 - {1'b0, cur_span}) : div_r2[31:0];
            quo_reg <= {quo_reg[QW-2:0], div_ge};
            if (div_cnt_reg == DCW'(QW - 1))
            begin
                if (axis_reg)
                    sy_reg <= {quo_reg[QW-2:0], div_ge};
                else
                    sx_reg <= {quo_reg[QW-2:0], div_ge};
            end
        end
        if (state_reg == ST_SQR)
        begin
            t2_reg <= 32'(t_cur) * 32'(t_cur);
            o2_reg <= 33'(om_cur) * 33'(om_cur);
        end
        if (state_reg == ST_CUBE)
        begin
            t3_reg <= 48'(t2_reg) * 48'(t_cur);
            o3_reg <= 49'(o2_reg) * 49'(om_cur);
        end
        for (int k = 0; k < 4; k++)
        begin
            if (state_reg == ST_NUM)
                num_reg[k] <= 20'((n_val[k] + HALF) >> 32);
            if (state_reg == ST_WGT)
            begin
                if (axis_reg)
                    wy_reg[k] <= WGT_W'((42'(num_reg[k]) * 42'(RECIP6)) >> RECIP6_SHIFT);
                else
                    wx_reg[k] <= WGT_W'((42'(num_reg[k]) * 42'(RECIP6)) >> RECIP6_SHIFT);
            end
        end
    end

    // sample decode, filter and neighborhood bounds
    always_ff @(posedge clk)
    begin
        tag1_reg  <= fcnt_reg;
        tag2_reg  <= tag1_reg;
        tag3_reg  <= tag2_reg;
        dprod_reg <= 48'(rdata_reg) * 48'(cfg.scale);
        samp_reg  <= $signed(SAMP_W'(dprod_reg[47:8])) + SAMP_W'(cfg.offset);
        if (v3_reg)
        begin
            if (tag3_reg == 4'd0 || samp_reg < lo_reg)
                lo_reg <= samp_reg;
            if (tag3_reg == 4'd0 || samp_reg > hi_reg)
                hi_reg <= samp_reg;
        end
        mprod_reg        <= mul_a * mul_w;
        mtag_reg.colpass <= col_issue;
        mtag_reg.idx     <= col_issue ? {2'b0, ccnt_reg} : tag3_reg;
        if (mv_reg)
        begin
            acc_reg <= acc_sum;
            if (mtag_reg.idx[1:0] == 2'd3)
            begin
                if (mtag_reg.colpass)
                    fin_reg <= ROW_W'(acc_rnd);
                else
                    row_reg[mtag_reg.idx[3:2]] <= ROW_W'(acc_rnd);
            end
        end
    end

    a_port_conflict: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("grid memory written and read in one cycle");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < cur_span))
        else $error("divider remainder not below divisor");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (lo_reg <= hi_reg))
        else $error("neighborhood minimum above maximum");

endmodule

/* sv/bspline_height_sampler_core.sv */
// bspline_height_sampler_core: top level of the cubic b-spline height sampler
// depends on bhs_pkg, bhs_front, bhs_fifo, bhs_back
// a store is written to the grid memory when it is popped from the queue;
// a query runs the bit-serial divider for each axis and then makes sixteen
// reads of the single-port grid memory
// up to QUEUE_DEPTH transactions wait between front and back; one result is held
// reset restores the configuration registers; grid contents are not cleared
module bspline_height_sampler_core #(
    parameter int GRID_SIDE   = bhs_pkg::GRID_SIDE_DEF,
    parameter int QUEUE_DEPTH = bhs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          kind,
    input  logic [15:0]                   cell_index,
    input  logic [15:0]                   cell_code,
    input  logic signed [31:0]            query_x_cm,
    input  logic signed [31:0]            query_y_cm,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [31:0]            height_q8,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bhs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import bhs_pkg::*;

    bhs_item_t   push_item, pop_item;
    bhs_cfg_t    cfg;
    logic        q_push, q_full, q_pop, q_empty;
    logic [31:0] res_height;

    // front: configuration and classification
    bhs_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .cell_index (cell_index),
        .cell_code  (cell_code),
        .query_x_cm (query_x_cm),
        .query_y_cm (query_y_cm),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item),
        .cfg        (cfg)
    );

    // queue between front and back
    bhs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    // back: grid, interpolation and result
    bhs_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .q_item     (pop_item),
        .cfg        (cfg),
        .res_pop    (pop),
        .res_empty  (empty),
        .res_height (res_height)
    );

    assign height_q8 = $signed(res_height);

endmodule
